[hw/rtl/fse_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fse_pkg: shared definitions of the float stack bytecode executor
// Opcodes, status codes, datapath selects and the control/status bundles
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package fse_pkg;

  // opcodes
  localparam logic [2:0] OP_PUSH = 3'd0;
  localparam logic [2:0] OP_NEG  = 3'd1;
  localparam logic [2:0] OP_ADD  = 3'd2;
  localparam logic [2:0] OP_SUB  = 3'd3;
  localparam logic [2:0] OP_MUL  = 3'd4;
  localparam logic [2:0] OP_DIV  = 3'd5;
  localparam logic [2:0] OP_RET  = 3'd6;

  // status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_UNDER = 3'd1;
  localparam logic [2:0] ST_OVER  = 3'd2;
  localparam logic [2:0] ST_RET   = 3'd3;
  localparam logic [2:0] ST_BAD   = 3'd4;

  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
  localparam logic [31:0] SIGN_MASK = 32'h8000_0000;

  typedef enum logic [2:0] {
    TOP_ZERO,
    TOP_RD1,
    TOP_CVAL,
    TOP_NEG,
    TOP_FPU
  } top_sel_e;

  typedef enum logic [1:0] {
    SP_HOLD,
    SP_INC,
    SP_DEC,
    SP_CLR
  } sp_op_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_PUSH,
    WR_NEG,
    WR_FPU
  } wr_sel_e;

  // controller to datapath
  typedef struct packed {
    logic     capture;
    logic     fpu_start;
    logic     commit;
    logic [2:0] op;
    logic [2:0] status;
    top_sel_e top_sel;
    sp_op_e   sp_op;
    wr_sel_e  wr_sel;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sp_zero;
    logic sp_lt2;
    logic sp_full;
    logic fpu_done;
  } stat_t;

endpackage

[hw/rtl/float_stack_bytecode_executor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_stack_bytecode_executor: binary32 stack machine
// Runs one instruction per request on an operand stack held in memory.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------------
//   in      | input     | in_valid_i / in_ready_o | mode_i, constant_value_i
//   out     | output    | out_valid_o/out_ready_i | top_value_o, stack_depth_o,
//           |           |                         | status_o
//
// Push, negate, return and error cases finish without the floating point unit.
// Add, subtract and multiply take an extra normalize step when the sum or
// product carries; nan or infinity operands and division by or of zero skip
// straight to rounding, and divide runs an iterative quotient loop. Each
// subnormal operand bit, cancelled bit or subnormal result adds a step in the normalize loops.
// The iterative floating point unit carries out the arithmetic.
// Reset empties the stack at once; no clearing pass is needed.
// A finished result waits in the output register while the next request is
// accepted; the commit of that next step waits until the slot is taken.
// ----------------------------------------------------------------------------
module float_stack_bytecode_executor #(
  parameter int STACK_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  mode_i,
  input  logic [31:0] constant_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] top_value_o,
  output logic [8:0]  stack_depth_o,
  output logic [2:0]  status_o
);

  fse_pkg::cmd_t  cmd;
  fse_pkg::stat_t stat;

  fse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (mode_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  fse_dp #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .constant_value_i(constant_value_i),
    .top_value_o     (top_value_o),
    .stack_depth_o   (stack_depth_o),
    .status_o        (status_o)
  );

endmodule

[hw/rtl/fse_fpu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fse_fpu: iterative binary32 add, subtract, multiply and divide
// Operands are unpacked and pre-normalized one bit a cycle, then aligned and
// added, multiplied once, or divided one quotient bit a cycle. A shared
// normalize loop and a round-to-nearest-even stage finish non-special cases.
// ----------------------------------------------------------------------------
module fse_fpu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [2:0]  op_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [31:0] res_o
);

  localparam logic [2:0] P_IDLE = 3'd0;
  localparam logic [2:0] P_PRE  = 3'd1;
  localparam logic [2:0] P_SET  = 3'd2;
  localparam logic [2:0] P_ADD  = 3'd3;
  localparam logic [2:0] P_MUL  = 3'd4;
  localparam logic [2:0] P_DIV  = 3'd5;
  localparam logic [2:0] P_NORM = 3'd6;
  localparam logic [2:0] P_RND  = 3'd7;

  logic [2:0]         ph_q, ph_d;
  logic               done_q;
  logic [2:0]         op_q;
  logic               sa_q, sb_q, rs_q;
  logic signed [10:0] ea_q, eb_q, e_q;
  logic [23:0]        ma_q, mb_q;
  logic [10:0]        d_q;
  logic [47:0]        p_q;
  logic [24:0]        r_q;
  logic [25:0]        q_q;
  logic [4:0]         cnt_q;
  logic [27:0]        m_q;
  logic               stk_q;
  logic               spec_q;
  logic [31:0]        spec_res_q;
  logic [31:0]        res_q;

  // operand classification at start
  logic [7:0] xa, xb;
  logic       a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sbe;
  logic       is_nan, is_inf, is_zero, sp_sign;
  logic [31:0] spec_res;

  always_comb begin
    xa     = a_i[30:23];
    xb     = b_i[30:23];
    a_nan  = (&xa) && (|a_i[22:0]);
    b_nan  = (&xb) && (|b_i[22:0]);
    a_inf  = (&xa) && !(|a_i[22:0]);
    b_inf  = (&xb) && !(|b_i[22:0]);
    a_zero = (a_i[30:0] == 31'd0);
    b_zero = (b_i[30:0] == 31'd0);
    sbe    = b_i[31] ^ (op_i == fse_pkg::OP_SUB);
    is_zero = 1'b0;
    if (op_i == fse_pkg::OP_ADD || op_i == fse_pkg::OP_SUB) begin
      is_nan  = a_nan | b_nan | (a_inf & b_inf & (a_i[31] != sbe));
      is_inf  = a_inf | b_inf;
      sp_sign = a_inf ? a_i[31] : sbe;
    end else if (op_i == fse_pkg::OP_MUL) begin
      is_nan  = a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
      is_inf  = a_inf | b_inf;
      sp_sign = a_i[31] ^ b_i[31];
    end else begin
      is_nan  = a_nan | b_nan | (a_inf & b_inf) | (a_zero & b_zero);
      is_inf  = a_inf | b_zero;
      is_zero = a_zero | b_inf;
      sp_sign = a_i[31] ^ b_i[31];
    end
    if (is_nan) begin
      spec_res = fse_pkg::CANON_NAN;
    end else if (is_inf) begin
      spec_res = {sp_sign, 8'hFF, 23'd0};
    end else begin
      spec_res = {sp_sign, 31'd0};
    end
  end

  // add path: align the smaller operand and add or subtract
  logic [4:0]  dcl;
  logic [53:0] al_wide;
  logic [26:0] al_sml;
  logic [27:0] sum;
  always_comb begin
    dcl     = (d_q > 11'd27) ? 5'd27 : d_q[4:0];
    al_wide = {mb_q, 3'b000, 27'd0} >> dcl;
    al_sml  = {al_wide[53:28], al_wide[27] | (|al_wide[26:0])};
    if (sa_q != sb_q) begin
      sum = {1'b0, ma_q, 3'b000} - {1'b0, al_sml};
    end else begin
      sum = {1'b0, ma_q, 3'b000} + {1'b0, al_sml};
    end
  end

  // divide step
  logic        ge;
  logic [24:0] rsub;
  always_comb begin
    ge   = (r_q >= {1'b0, mb_q});
    rsub = ge ? (r_q - {1'b0, mb_q}) : r_q;
  end

  // normalize: right shift for tiny exponents
  logic signed [10:0] rsh;
  logic [4:0]         amt;
  logic [59:0]        rs_wide;
  always_comb begin
    rsh     = 11'sd1 - e_q;
    amt     = (rsh > 11'sd31) ? 5'd31 : rsh[4:0];
    rs_wide = {m_q, 32'd0} >> amt;
  end

  // round to nearest even and pack
  logic [23:0]        mant;
  logic               inc;
  logic [24:0]        s25;
  logic [23:0]        mf;
  logic signed [10:0] er;
  logic [31:0]        rnd_res;
  always_comb begin
    mant = m_q[26:3];
    inc  = m_q[2] & ((|m_q[1:0]) | stk_q | m_q[3]);
    s25  = {1'b0, mant} + {24'd0, inc};
    mf   = s25[24] ? s25[24:1] : s25[23:0];
    er   = s25[24] ? (e_q + 11'sd1) : e_q;
    if (spec_q) begin
      rnd_res = spec_res_q;
    end else if (er >= 11'sd255) begin
      rnd_res = {rs_q, 8'hFF, 23'd0};
    end else begin
      rnd_res = {rs_q, (mf[23] ? er[7:0] : 8'd0), mf[22:0]};
    end
  end

  // phase sequencing
  logic na, nb;
  always_comb begin
    na   = (ma_q != 24'd0) && !ma_q[23];
    nb   = (mb_q != 24'd0) && !mb_q[23];
    ph_d = ph_q;
    unique case (ph_q)
      P_IDLE: if (start_i) ph_d = (is_nan | is_inf | is_zero) ? P_RND : P_PRE;
      P_PRE:  if (!na && !nb) ph_d = P_SET;
      P_SET: begin
        if (op_q == fse_pkg::OP_MUL) begin
          ph_d = P_MUL;
        end else if (op_q == fse_pkg::OP_DIV) begin
          ph_d = P_DIV;
        end else begin
          ph_d = P_ADD;
        end
      end
      P_ADD:  ph_d = P_NORM;
      P_MUL:  ph_d = P_NORM;
      P_DIV:  if (cnt_q == 5'd1) ph_d = P_NORM;
      P_NORM: begin
        if (!m_q[27] && (e_q >= 11'sd1) &&
            !(!m_q[26] && (m_q != 28'd0) && (e_q > 11'sd1))) begin
          ph_d = P_RND;
        end
      end
      P_RND:  ph_d = P_IDLE;
      default: ph_d = P_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= P_IDLE;
      done_q <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      done_q <= (ph_q == P_RND);
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    unique case (ph_q)
      P_IDLE: begin
        if (start_i) begin
          op_q       <= op_i;
          sa_q       <= a_i[31];
          sb_q       <= sbe;
          ea_q       <= (xa == 8'd0) ? 11'sd1 : $signed({3'b000, xa});
          eb_q       <= (xb == 8'd0) ? 11'sd1 : $signed({3'b000, xb});
          ma_q       <= {|xa, a_i[22:0]};
          mb_q       <= {|xb, b_i[22:0]};
          spec_q     <= is_nan | is_inf | is_zero;
          spec_res_q <= spec_res;
        end
      end
      P_PRE: begin
        if (na) begin
          ma_q <= {ma_q[22:0], 1'b0};
          ea_q <= ea_q - 11'sd1;
        end
        if (nb) begin
          mb_q <= {mb_q[22:0], 1'b0};
          eb_q <= eb_q - 11'sd1;
        end
      end
      P_SET: begin
        if (op_q == fse_pkg::OP_MUL) begin
          p_q  <= ma_q * mb_q;
          e_q  <= ea_q + eb_q - 11'sd127;
          rs_q <= sa_q ^ sb_q;
        end else if (op_q == fse_pkg::OP_DIV) begin
          e_q   <= ea_q - eb_q + 11'sd127;
          r_q   <= {1'b0, ma_q};
          cnt_q <= 5'd27;
          rs_q  <= sa_q ^ sb_q;
        end else if ((ea_q > eb_q) || ((ea_q == eb_q) && (ma_q >= mb_q))) begin
          d_q <= 11'(ea_q - eb_q);
        end else begin
          // larger magnitude goes first
          ea_q <= eb_q;
          eb_q <= ea_q;
          ma_q <= mb_q;
          mb_q <= ma_q;
          sa_q <= sb_q;
          sb_q <= sa_q;
          d_q  <= 11'(eb_q - ea_q);
        end
      end
      P_ADD: begin
        m_q   <= sum;
        e_q   <= ea_q;
        stk_q <= 1'b0;
        rs_q  <= (sum == 28'd0) ? (sa_q & sb_q) : sa_q;
      end
      P_MUL: begin
        m_q   <= p_q[47:20];
        stk_q <= |p_q[19:0];
      end
      P_DIV: begin
        r_q   <= {rsub[23:0], 1'b0};
        q_q   <= {q_q[24:0], ge};
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          m_q   <= {1'b0, q_q, ge};
          stk_q <= (rsub != 25'd0);
        end
      end
      P_NORM: begin
        if (m_q[27]) begin
          m_q   <= {1'b0, m_q[27:1]};
          stk_q <= stk_q | m_q[0];
          e_q   <= e_q + 11'sd1;
        end else if (e_q < 11'sd1) begin
          m_q   <= rs_wide[59:32];
          stk_q <= stk_q | (|rs_wide[31:0]);
          e_q   <= 11'sd1;
        end else if (!m_q[26] && (m_q != 28'd0) && (e_q > 11'sd1)) begin
          m_q <= {m_q[26:0], 1'b0};
          e_q <= e_q - 11'sd1;
        end
      end
      P_RND: res_q <= rnd_res;
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

[hw/rtl/fse_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fse_dp: operand stack datapath
// Stack memory with two registered read ports, stack pointer, operand
// capture, floating point unit and the result register.
// ----------------------------------------------------------------------------
module fse_dp #(
  parameter int STACK_DEPTH = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  fse_pkg::cmd_t cmd_i,
  output fse_pkg::stat_t stat_o,
  input  logic [31:0]   constant_value_i,
  output logic [31:0]   top_value_o,
  output logic [8:0]    stack_depth_o,
  output logic [2:0]    status_o
);

  localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  logic [31:0]    stack_mem [STACK_DEPTH];
  logic [SPW-1:0] sp_q, sp_d;
  logic [31:0]    cval_q, rd1_q, rd2_q;
  logic [31:0]    top_q;
  logic [8:0]     depth_q;
  logic [2:0]     status_q;
  logic           fpu_done;
  logic [31:0]    fpu_res;
  logic [AW-1:0]  rd1_addr, rd2_addr, wr_addr;
  logic [31:0]    wr_data, top_d;
  logic           wr_en;

  // stack flags
  assign stat_o.sp_zero  = (sp_q == '0);
  assign stat_o.sp_lt2   = (sp_q < SPW'(2));
  assign stat_o.sp_full  = (sp_q == SPW'(STACK_DEPTH));
  assign stat_o.fpu_done = fpu_done;

  assign rd1_addr = AW'(sp_q - SPW'(1));
  assign rd2_addr = AW'(sp_q - SPW'(2));

  // next stack pointer
  always_comb begin
    unique case (cmd_i.sp_op)
      fse_pkg::SP_INC: sp_d = sp_q + SPW'(1);
      fse_pkg::SP_DEC: sp_d = sp_q - SPW'(1);
      fse_pkg::SP_CLR: sp_d = '0;
      default:         sp_d = sp_q;
    endcase
  end

  // write port
  always_comb begin
    wr_en   = cmd_i.commit && (cmd_i.wr_sel != fse_pkg::WR_NONE);
    wr_addr = AW'(sp_q);
    wr_data = cval_q;
    unique case (cmd_i.wr_sel)
      fse_pkg::WR_NEG: begin
        wr_addr = rd1_addr;
        wr_data = rd1_q ^ fse_pkg::SIGN_MASK;
      end
      fse_pkg::WR_FPU: begin
        wr_addr = rd2_addr;
        wr_data = fpu_res;
      end
      default: ;
    endcase
  end

  // top of stack after the step
  always_comb begin
    unique case (cmd_i.top_sel)
      fse_pkg::TOP_RD1:  top_d = rd1_q;
      fse_pkg::TOP_CVAL: top_d = cval_q;
      fse_pkg::TOP_NEG:  top_d = rd1_q ^ fse_pkg::SIGN_MASK;
      fse_pkg::TOP_FPU:  top_d = fpu_res;
      default:           top_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    if (cmd_i.capture) begin
      rd1_q  <= stack_mem[rd1_addr];
      rd2_q  <= stack_mem[rd2_addr];
      cval_q <= constant_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
    end else if (cmd_i.commit) begin
      sp_q <= sp_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      top_q    <= top_d;
      depth_q  <= 9'(sp_d);
      status_q <= cmd_i.status;
    end
  end

  fse_fpu u_fpu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.fpu_start),
    .op_i   (cmd_i.op),
    .a_i    (rd2_q),
    .b_i    (rd1_q),
    .done_o (fpu_done),
    .res_o  (fpu_res)
  );

  assign top_value_o   = top_q;
  assign stack_depth_o = depth_q;
  assign status_o      = status_q;

endmodule

[hw/rtl/fse_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fse_ctrl: instruction sequencer
// Accepts one request, decodes it against the stack flags, runs the
// floating point unit when needed and commits the step into the result slot.
// ----------------------------------------------------------------------------
module fse_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [2:0]     mode_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output fse_pkg::cmd_t  cmd_o,
  input  fse_pkg::stat_t stat_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_FPU  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_q, state_d;
  logic [2:0] op_q;
  logic       out_valid_q, out_valid_d;
  logic       is_arith, slot_free;

  assign is_arith  = (op_q == fse_pkg::OP_ADD) || (op_q == fse_pkg::OP_SUB) ||
                     (op_q == fse_pkg::OP_MUL) || (op_q == fse_pkg::OP_DIV);
  assign slot_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  // decode and sequencing
  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.op        = op_q;
    cmd_o.capture   = in_valid_i && in_ready_o;
    cmd_o.status    = fse_pkg::ST_OK;
    cmd_o.top_sel   = stat_i.sp_zero ? fse_pkg::TOP_ZERO : fse_pkg::TOP_RD1;
    cmd_o.sp_op     = fse_pkg::SP_HOLD;
    cmd_o.wr_sel    = fse_pkg::WR_NONE;

    unique case (op_q)
      fse_pkg::OP_PUSH: begin
        if (stat_i.sp_full) begin
          cmd_o.status = fse_pkg::ST_OVER;
        end else begin
          cmd_o.top_sel = fse_pkg::TOP_CVAL;
          cmd_o.sp_op   = fse_pkg::SP_INC;
          cmd_o.wr_sel  = fse_pkg::WR_PUSH;
        end
      end
      fse_pkg::OP_NEG: begin
        if (stat_i.sp_zero) begin
          cmd_o.status = fse_pkg::ST_UNDER;
        end else begin
          cmd_o.top_sel = fse_pkg::TOP_NEG;
          cmd_o.wr_sel  = fse_pkg::WR_NEG;
        end
      end
      fse_pkg::OP_ADD, fse_pkg::OP_SUB, fse_pkg::OP_MUL, fse_pkg::OP_DIV: begin
        if (stat_i.sp_lt2) begin
          cmd_o.status = fse_pkg::ST_UNDER;
        end else begin
          cmd_o.top_sel = fse_pkg::TOP_FPU;
          cmd_o.sp_op   = fse_pkg::SP_DEC;
          cmd_o.wr_sel  = fse_pkg::WR_FPU;
        end
      end
      fse_pkg::OP_RET: begin
        cmd_o.status = fse_pkg::ST_RET;
        cmd_o.sp_op  = fse_pkg::SP_CLR;
      end
      default: cmd_o.status = fse_pkg::ST_BAD;
    endcase

    unique case (state_q)
      S_IDLE: if (cmd_o.capture) state_d = S_EXEC;
      S_EXEC: begin
        if (is_arith && !stat_i.sp_lt2) begin
          cmd_o.fpu_start = 1'b1;
          state_d         = S_FPU;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FPU: if (stat_i.fpu_done) state_d = S_FIN;
      S_FIN: begin
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // result slot valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.commit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      op_q        <= fse_pkg::OP_PUSH;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cmd_o.capture) op_q <= mode_i;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[hw/rtl/fse_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fse_checker: port level checks of the stack executor
// Watches the handshakes and the reported results over time.
// ----------------------------------------------------------------------------
module fse_checker #(
  parameter int STACK_DEPTH = 256
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] top_value_o,
  input logic [8:0]  stack_depth_o,
  input logic [2:0]  status_o
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(top_value_o) &&
      $stable(stack_depth_o) && $stable(status_o))
    else $error("stalled result changed");

  // one request in flight at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while busy");

  // return leaves an empty stack
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == fse_pkg::ST_RET) |-> stack_depth_o == 9'd0)
    else $error("return with nonzero depth");

  // overflow only on a full stack
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == fse_pkg::ST_OVER) |->
      stack_depth_o == 9'(STACK_DEPTH))
    else $error("overflow below full depth");

  // underflow only with fewer than two entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == fse_pkg::ST_UNDER) |-> stack_depth_o <= 9'd1)
    else $error("underflow with deep stack");

endmodule

bind float_stack_bytecode_executor fse_checker #(
  .STACK_DEPTH(STACK_DEPTH)
) u_fse_checker (.*);
